/* rtl/gfh_pkg.sv */
// gfh_pkg: shared types and codes for the gated frequency histogram.
// Request and result payload structs, request codes and sequencer states.
// No dependencies.
package gfh_pkg;

  localparam int FREQ_W   = 24;
  localparam int RATE_W   = 16;
  localparam int STREN_W  = 16;
  localparam int CFG_W    = 12;
  localparam int RES_CNT_W = 32;
  localparam int FRAC_W   = 4;   // pulse rate is Q12.4
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef enum logic [1:0] {
    REQ_DETECT    = 2'd0,
    REQ_CLEAR_ONE = 2'd1,
    REQ_CLEAR_ALL = 2'd2,
    REQ_UNUSED    = 2'd3
  } req_code_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_TARGET_RATE    = 1'b0,
    REG_RATE_TOLERANCE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [FREQ_W-1:0]         frequency;
    logic signed [STREN_W-1:0] strength;
    logic [RATE_W-1:0]         pulse_rate;
  } req_t;

  typedef struct packed {
    logic [FREQ_W-1:0]    freq;
    logic [RES_CNT_W-1:0] samples;
    logic [RES_CNT_W-1:0] strong_samples;
    logic                 last_entry;
  } res_t;

endpackage

/* rtl/gfh_table.sv */
// gfh_table: single-port-write, single-read table of frequency entries.
// Holds key, sample count and strong count per entry; read data registered.
// Depends on gfh_pkg for the key width.
module gfh_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CB    = 32
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [gfh_pkg::FREQ_W-1:0] wr_key,
  input  logic [CB-1:0]             wr_hit,
  input  logic [CB-1:0]             wr_strong,
  input  logic [AW-1:0]             rd_addr,
  output logic [gfh_pkg::FREQ_W-1:0] rd_key,
  output logic [CB-1:0]             rd_hit,
  output logic [CB-1:0]             rd_strong
);

  logic [gfh_pkg::FREQ_W-1:0] key_mem    [DEPTH];
  logic [CB-1:0]              hit_mem    [DEPTH];
  logic [CB-1:0]              strong_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]    <= wr_key;
      hit_mem[wr_addr]    <= wr_hit;
      strong_mem[wr_addr] <= wr_strong;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    rd_key    <= key_mem[rd_addr];
    rd_hit    <= hit_mem[rd_addr];
    rd_strong <= strong_mem[rd_addr];
  end

endmodule

/* rtl/gated_frequency_histogram.sv */
// gated_frequency_histogram: top level, sequencer, config registers, result register.
// Depends on gfh_pkg and gfh_table.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | gfh_pkg::req_t
//  res     | out       | res_valid/res_ready | gfh_pkg::res_t
//  apb     | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// One request at a time; req_ready is high only while the sequencer is idle.
// A detection scans to the slot, shifts the tail up when it inserts a new key,
// then gives one result per cycle while res_ready does not stall it; the pace
// is set by the table's one read port. Results stall on res_ready.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
module gated_frequency_histogram #(
  parameter int NUM_FREQS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  gfh_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output gfh_pkg::res_t                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gfh_pkg::APB_AW-1:0]    paddr,
  input  logic [gfh_pkg::APB_DW-1:0]    pwdata,
  output logic [gfh_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int AW = (NUM_FREQS > 1) ? $clog2(NUM_FREQS) : 1;
  localparam int CW = $clog2(NUM_FREQS + 1);
  localparam logic [CW-1:0] FULL = CW'(NUM_FREQS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // ---------------- configuration ----------------
  logic [gfh_pkg::CFG_W-1:0] target_rate;
  logic [gfh_pkg::CFG_W-1:0] rate_tolerance;
  logic                      cfg_wr;
  gfh_pkg::reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = gfh_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate    <= '0;
      rate_tolerance <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gfh_pkg::REG_TARGET_RATE:    target_rate    <= pwdata[gfh_pkg::CFG_W-1:0];
        gfh_pkg::REG_RATE_TOLERANCE: rate_tolerance <= pwdata[gfh_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gfh_pkg::REG_TARGET_RATE:    prdata = gfh_pkg::APB_DW'(target_rate);
      gfh_pkg::REG_RATE_TOLERANCE: prdata = gfh_pkg::APB_DW'(rate_tolerance);
      default:                     prdata = '0;
    endcase
  end

  // ---------------- table ----------------
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [gfh_pkg::FREQ_W-1:0] wr_key;
  logic [COUNT_BITS-1:0]      wr_hit;
  logic [COUNT_BITS-1:0]      wr_strong;
  logic [AW-1:0]              rd_addr;
  logic [gfh_pkg::FREQ_W-1:0] rd_key;
  logic [COUNT_BITS-1:0]      rd_hit;
  logic [COUNT_BITS-1:0]      rd_strong;

  gfh_table #(
    .DEPTH (NUM_FREQS),
    .AW    (AW),
    .CB    (COUNT_BITS)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_hit    (wr_hit),
    .wr_strong (wr_strong),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_hit    (rd_hit),
    .rd_strong (rd_strong)
  );

  // ---------------- sequencer ----------------
  gfh_pkg::state_t state, state_next;
  gfh_pkg::req_t   req_q;
  logic [CW-1:0]   used, used_next;
  logic [CW-1:0]   idx, idx_next;
  logic [CW-1:0]   pos, pos_next;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec2;
  logic [CW-1:0]   used_dec;
  logic            load_res;
  logic            res_last;

  logic [gfh_pkg::RATE_W-1:0] tgt_q;
  logic [gfh_pkg::RATE_W-1:0] tol_q;
  logic [gfh_pkg::RATE_W-1:0] dev;
  logic                       gate_ok;
  logic                       strong_det;
  logic                       is_clear;

  assign req_ready = (state == gfh_pkg::S_IDLE);

  // rate gate, exact in Q12.4
  assign tgt_q   = {target_rate, {gfh_pkg::FRAC_W{1'b0}}};
  assign tol_q   = {rate_tolerance, {gfh_pkg::FRAC_W{1'b0}}};
  assign dev     = (req_q.pulse_rate >= tgt_q) ? req_q.pulse_rate - tgt_q
                                               : tgt_q - req_q.pulse_rate;
  assign gate_ok = (dev <= tol_q);

  assign strong_det = (req_q.strength > 16'sd0);
  assign is_clear   = (req_q.req_type == gfh_pkg::REQ_CLEAR_ONE);
  assign idx_inc    = idx + CW'(1);
  assign idx_dec2   = idx - CW'(2);
  assign used_dec   = used - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfh_pkg::S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    pos <= pos_next;
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    idx_next   = idx;
    pos_next   = pos;
    rd_addr    = idx[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx[AW-1:0];
    wr_key     = req_q.frequency;
    wr_hit     = '0;
    wr_strong  = '0;
    load_res   = 1'b0;
    res_last   = 1'b0;

    case (state)
      gfh_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = gfh_pkg::S_DISPATCH;
        end
      end

      gfh_pkg::S_DISPATCH: begin
        idx_next = '0;
        rd_addr  = '0;
        case (req_q.req_type)
          gfh_pkg::REQ_DETECT:
            state_next = gate_ok ? gfh_pkg::S_SEARCH : gfh_pkg::S_IDLE;
          gfh_pkg::REQ_CLEAR_ONE:
            state_next = gfh_pkg::S_SEARCH;
          gfh_pkg::REQ_CLEAR_ALL: begin
            used_next  = '0;
            state_next = gfh_pkg::S_IDLE;
          end
          default:
            state_next = gfh_pkg::S_IDLE;
        endcase
      end

      // table is sorted: stop at the first key not below the request
      gfh_pkg::S_SEARCH: begin
        if (idx != used && rd_key == req_q.frequency) begin
          wr_en   = 1'b1;
          wr_key  = rd_key;
          if (is_clear) begin
            state_next = gfh_pkg::S_IDLE;
          end else begin
            wr_hit     = (rd_hit == CNT_MAX) ? rd_hit : rd_hit + COUNT_BITS'(1);
            wr_strong  = (strong_det && rd_strong != CNT_MAX) ? rd_strong + COUNT_BITS'(1)
                                                              : rd_strong;
            state_next = gfh_pkg::S_EMIT_RD;
          end
        end else if (idx == used || rd_key > req_q.frequency) begin
          if (is_clear || used == FULL) begin
            state_next = gfh_pkg::S_IDLE;
          end else begin
            pos_next   = idx;
            idx_next   = used;
            rd_addr    = used_dec[AW-1:0];
            state_next = gfh_pkg::S_SHIFT;
          end
        end else begin
          idx_next = idx_inc;
          rd_addr  = idx_inc[AW-1:0];
        end
      end

      // move entries up one slot from the top down, then drop the new key in
      gfh_pkg::S_SHIFT: begin
        wr_en = 1'b1;
        if (idx == pos) begin
          wr_key     = req_q.frequency;
          wr_hit     = COUNT_BITS'(1);
          wr_strong  = strong_det ? COUNT_BITS'(1) : '0;
          used_next  = used + CW'(1);
          state_next = gfh_pkg::S_EMIT_RD;
        end else begin
          wr_key    = rd_key;
          wr_hit    = rd_hit;
          wr_strong = rd_strong;
          idx_next  = idx - CW'(1);
          rd_addr   = idx_dec2[AW-1:0];
        end
      end

      gfh_pkg::S_EMIT_RD: begin
        idx_next   = '0;
        rd_addr    = '0;
        state_next = gfh_pkg::S_EMIT;
      end

      // rd_key/rd_hit/rd_strong hold entry idx; fetch the next one as each transfer is loaded
      gfh_pkg::S_EMIT: begin
        if (!res_valid || res_ready) begin
          load_res = 1'b1;
          res_last = (idx_inc == used);
          if (res_last) begin
            state_next = gfh_pkg::S_IDLE;
          end else begin
            idx_next = idx_inc;
            rd_addr  = idx_inc[AW-1:0];
          end
        end
      end

      default: state_next = gfh_pkg::S_IDLE;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.freq           <= rd_key;
      res.samples        <= gfh_pkg::RES_CNT_W'(rd_hit);
      res.strong_samples <= gfh_pkg::RES_CNT_W'(rd_strong);
      res.last_entry     <= res_last;
    end
  end

endmodule
